### hw/rtl/tq_pkg.sv
// Shared types, codes and constants for the timer queue.
// Used by tq_alu, the top level of the timer queue and the bench; depends on nothing.
`timescale 1ns / 1ps

package tq_pkg;

    localparam int TIMER_SLOTS_DEF = 64;
    localparam int CONNECTIONS_DEF = 256;
    localparam int MAX_OUT         = 64;
    localparam int N_W             = 7;
    localparam int TIME_W          = 40;
    localparam int TMO_W           = 24;
    localparam int CONN_W          = 8;
    localparam int HND_W           = 4;
    localparam int SERIAL_W        = 16;

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_FIND   = 2'd2,
        MODE_EXPIRE = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        KIND_ADD_DONE = 3'd0,
        KIND_DEL_DONE = 3'd1,
        KIND_WAIT     = 3'd2,
        KIND_EXPIRED  = 3'd3,
        KIND_NONE_DUE = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NO_TIMER = 2'd2
    } status_t;

    typedef enum logic {
        ALU_ADD_SAT = 1'b0,
        ALU_SUB     = 1'b1
    } alu_op_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD_SUM,
        S_ADD_RD,
        S_ADD_CMP,
        S_DEL_LT,
        S_DEL_LTW,
        S_DEL_RD,
        S_DEL_CMP,
        S_DROP_CHK,
        S_DROP_EV
    } state_t;

    typedef struct packed {
        logic [TIME_W-1:0]   deadline;
        logic [CONN_W-1:0]   conn;
        logic [HND_W-1:0]    hnd;
        logic [SERIAL_W-1:0] serial;
        logic                dead;
    } entry_t;

    typedef struct packed {
        logic                valid;
        logic [SERIAL_W-1:0] serial;
    } latest_t;

endpackage

### hw/rtl/tq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module tq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/tq_alu.sv
// Shared 40-bit arithmetic unit: saturating add, or subtract with greater-than flag.
// Depends on tq_pkg.
`timescale 1ns / 1ps

module tq_alu (
    input  tq_pkg::alu_op_t             op,
    input  logic [tq_pkg::TIME_W-1:0]   a,
    input  logic [tq_pkg::TIME_W-1:0]   b,
    output logic [tq_pkg::TIME_W-1:0]   res,
    output logic                        gt
);
    import tq_pkg::*;

    logic [TIME_W:0] sum;
    logic [TIME_W:0] diff;

    always_comb
    begin
        sum  = {1'b0, a} + {1'b0, b};
        diff = {1'b0, a} - {1'b0, b};
        gt   = !diff[TIME_W] && (diff[TIME_W-1:0] != '0);
        case (op)
            ALU_ADD_SAT: res = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
            ALU_SUB:     res = diff[TIME_W-1:0];
            default:     res = diff[TIME_W-1:0];
        endcase
    end

endmodule

### hw/rtl/timer_queue_lazy_delete.sv
// Top level of the deadline-ordered timer queue with lazy deletion.
// Depends on tq_pkg, tq_ram and tq_alu.
`timescale 1ns / 1ps

// After reset the block runs a clearing pass over the per-connection table,
// one entry a cycle, with busy high. A word is taken when start is high and
// busy is low; busy then stays high until the word is done. Results appear
// for one cycle each with result_valid and cannot be stalled; last marks the
// final result of a word. The queue lives in one RAM with a registered read,
// so each entry visited takes a read state and a compare state: an add walks
// the entries with a later deadline, a delete walks to the match or through
// all queued entries, find drops the dead entries at the head, and expire
// drops dead entries and emits due timers. A full add is answered without
// going busy.
module timer_queue_lazy_delete #(
    parameter int TIMER_SLOTS = tq_pkg::TIMER_SLOTS_DEF,
    parameter int CONNECTIONS = tq_pkg::CONNECTIONS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [1:0]                    mode,
    input  logic [tq_pkg::TIME_W-1:0]     now_ms,
    input  logic [tq_pkg::CONN_W-1:0]     connection_id,
    input  logic [tq_pkg::TMO_W-1:0]      timeout_ms,
    input  logic [tq_pkg::HND_W-1:0]      handler_id,
    output logic                          busy,
    output logic                          result_valid,
    output logic [2:0]                    kind,
    output logic [1:0]                    status,
    output logic [tq_pkg::CONN_W-1:0]     expired_connection,
    output logic [tq_pkg::HND_W-1:0]      expired_handler,
    output logic [tq_pkg::TMO_W-1:0]      wait_ms,
    output logic                          none_pending,
    output logic                          last
);
    import tq_pkg::*;

    localparam int AW = $clog2(TIMER_SLOTS);
    localparam int CW = $clog2(CONNECTIONS);
    localparam logic [AW:0] SLOTS = (AW+1)'(TIMER_SLOTS);

    function automatic logic [CW-1:0] conn_index(input logic [CONN_W-1:0] c);
        logic [31:0] x;
        x = 32'(c);
        for (int b = CONN_W - 1; b >= 0; b--)
        begin
            if (x >= (32'(CONNECTIONS) << b))
            begin
                x = x - (32'(CONNECTIONS) << b);
            end
        end
        return x[CW-1:0];
    endfunction

    state_t              state_reg, state_next;
    logic [AW-1:0]       head_reg, head_next;
    logic [AW:0]         count_reg, count_next;
    logic [AW:0]         k_reg, k_next;
    logic [N_W-1:0]      n_reg, n_next;
    logic [SERIAL_W-1:0] serial_reg, serial_next;
    logic [CW-1:0]       clr_reg, clr_next;
    logic                pend_reg, pend_next;

    mode_t               mode_reg, mode_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [CONN_W-1:0]   conn_reg, conn_next;
    logic [TMO_W-1:0]    tmo_reg, tmo_next;
    logic [HND_W-1:0]    hnd_reg, hnd_next;
    logic [TIME_W-1:0]   dl_reg, dl_next;
    logic [CONN_W-1:0]   pconn_reg, pconn_next;
    logic [HND_W-1:0]    phnd_reg, phnd_next;

    logic                res_valid_reg, res_valid_next;
    kind_t               kind_reg, kind_next;
    status_t             status_reg, status_next;
    logic [CONN_W-1:0]   xconn_reg, xconn_next;
    logic [HND_W-1:0]    xhnd_reg, xhnd_next;
    logic [TMO_W-1:0]    wait_reg, wait_next;
    logic                none_reg, none_next;
    logic                last_reg, last_next;

    logic                q_we, q_re;
    logic [AW-1:0]       q_waddr, q_raddr;
    entry_t              q_wdata, q_rd;
    logic [$bits(entry_t)-1:0] q_rdata;

    logic                lt_we, lt_re;
    logic [CW-1:0]       lt_waddr, lt_raddr;
    latest_t             lt_wdata, lt_rd;
    logic [$bits(latest_t)-1:0] lt_rdata;

    alu_op_t             alu_op;
    logic [TIME_W-1:0]   alu_a, alu_b, alu_res;
    logic                alu_gt;

    logic                ins_fire, del_hit, live_stop;
    logic [AW-1:0]       pos_k, pos_km1;
    entry_t              new_entry;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [AW:0] k);
        logic [AW:0] s;
        s = {1'b0, h} + k;
        if (s >= SLOTS)
        begin
            s = s - SLOTS;
        end
        return s[AW-1:0];
    endfunction

    tq_ram #(.WIDTH($bits(entry_t)), .DEPTH(TIMER_SLOTS)) u_queue (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .re    (q_re),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    tq_ram #(.WIDTH($bits(latest_t)), .DEPTH(CONNECTIONS)) u_latest (
        .clk   (clk),
        .we    (lt_we),
        .waddr (lt_waddr),
        .wdata (lt_wdata),
        .re    (lt_re),
        .raddr (lt_raddr),
        .rdata (lt_rdata)
    );

    tq_alu u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res),
        .gt  (alu_gt)
    );

    assign q_rd    = entry_t'(q_rdata);
    assign lt_rd   = latest_t'(lt_rdata);
    assign pos_k   = phys(head_reg, k_reg);
    assign pos_km1 = phys(head_reg, k_reg - 1'b1);

    always_comb
    begin
        alu_op = ALU_SUB;
        alu_a  = q_rd.deadline;
        alu_b  = now_reg;
        case (state_reg)
            S_ADD_SUM:
            begin
                alu_op = ALU_ADD_SAT;
                alu_a  = now_reg;
                alu_b  = TIME_W'(tmo_reg);
            end
            S_ADD_CMP: alu_b = dl_reg;
            default:   alu_b = now_reg;
        endcase
    end

    assign new_entry = '{deadline: dl_reg, conn: conn_reg, hnd: hnd_reg,
                         serial: serial_reg, dead: 1'b0};
    assign ins_fire  = (state_reg == S_ADD_RD && k_reg == '0)
                    || (state_reg == S_ADD_CMP && !alu_gt);
    assign del_hit   = state_reg == S_DEL_CMP && q_rd.conn == conn_reg
                    && q_rd.serial == lt_rd.serial;
    assign live_stop = state_reg == S_DROP_EV && !q_rd.dead
                    && (mode_reg == MODE_FIND || alu_gt || n_reg >= N_W'(MAX_OUT));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == CW'(CONNECTIONS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    case (mode_t'(mode))
                        MODE_ADD:    state_next = (count_reg == SLOTS) ? S_IDLE : S_ADD_SUM;
                        MODE_DELETE: state_next = S_DEL_LT;
                        default:     state_next = S_DROP_CHK;
                    endcase
                end
            end
            S_ADD_SUM: state_next = S_ADD_RD;
            S_ADD_RD:  state_next = (k_reg == '0) ? S_IDLE : S_ADD_CMP;
            S_ADD_CMP: state_next = alu_gt ? S_ADD_RD : S_IDLE;
            S_DEL_LT:  state_next = S_DEL_LTW;
            S_DEL_LTW: state_next = lt_rd.valid ? S_DEL_RD : S_IDLE;
            S_DEL_RD:  state_next = (k_reg == count_reg) ? S_IDLE : S_DEL_CMP;
            S_DEL_CMP: state_next = del_hit ? S_IDLE : S_DEL_RD;
            S_DROP_CHK: state_next = (count_reg == '0) ? S_IDLE : S_DROP_EV;
            S_DROP_EV:  state_next = live_stop ? S_IDLE : S_DROP_CHK;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        k_next      = k_reg;
        n_next      = n_reg;
        serial_next = serial_reg;
        clr_next    = clr_reg;
        pend_next   = pend_reg;
        mode_next   = mode_reg;
        now_next    = now_reg;
        conn_next   = conn_reg;
        tmo_next    = tmo_reg;
        hnd_next    = hnd_reg;
        dl_next     = dl_reg;
        pconn_next  = pconn_reg;
        phnd_next   = phnd_reg;

        res_valid_next = 1'b0;
        kind_next      = KIND_ADD_DONE;
        status_next    = ST_OK;
        xconn_next     = '0;
        xhnd_next      = '0;
        wait_next      = '0;
        none_next      = 1'b0;
        last_next      = 1'b1;

        q_we     = 1'b0;
        q_waddr  = pos_k;
        q_wdata  = new_entry;
        q_re     = 1'b0;
        q_raddr  = pos_km1;
        lt_we    = 1'b0;
        lt_waddr = conn_index(conn_reg);
        lt_wdata = '{valid: 1'b1, serial: serial_reg};
        lt_re    = 1'b0;
        lt_raddr = conn_index(conn_reg);

        case (state_reg)
            S_CLEAR:
            begin
                lt_we    = 1'b1;
                lt_waddr = clr_reg;
                lt_wdata = '0;
                clr_next = clr_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    mode_next = mode_t'(mode);
                    now_next  = now_ms;
                    conn_next = connection_id;
                    tmo_next  = timeout_ms;
                    hnd_next  = handler_id;
                    n_next    = '0;
                    pend_next = 1'b0;
                    if (mode_t'(mode) == MODE_ADD && count_reg == SLOTS)
                    begin
                        res_valid_next = 1'b1;
                        status_next    = ST_FULL;
                    end
                end
            end
            S_ADD_SUM:
            begin
                dl_next = alu_res;
                k_next  = count_reg;
            end
            S_ADD_RD:
            begin
                q_re = k_reg != '0;
            end
            S_ADD_CMP:
            begin
                if (alu_gt)
                begin
                    q_we    = 1'b1;
                    q_wdata = q_rd;
                    k_next  = k_reg - 1'b1;
                end
            end
            S_DEL_LT:
            begin
                lt_re = 1'b1;
            end
            S_DEL_LTW:
            begin
                k_next = '0;
                if (!lt_rd.valid)
                begin
                    res_valid_next = 1'b1;
                    kind_next      = KIND_DEL_DONE;
                    status_next    = ST_NO_TIMER;
                end
            end
            S_DEL_RD:
            begin
                q_re    = 1'b1;
                q_raddr = pos_k;
                if (k_reg == count_reg)
                begin
                    res_valid_next = 1'b1;
                    kind_next      = KIND_DEL_DONE;
                    status_next    = ST_NO_TIMER;
                end
            end
            S_DEL_CMP:
            begin
                if (del_hit)
                begin
                    q_we           = 1'b1;
                    q_wdata        = q_rd;
                    q_wdata.dead   = 1'b1;
                    res_valid_next = 1'b1;
                    kind_next      = KIND_DEL_DONE;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_DROP_CHK:
            begin
                q_re    = 1'b1;
                q_raddr = head_reg;
                if (count_reg == '0)
                begin
                    res_valid_next = 1'b1;
                    if (mode_reg == MODE_FIND)
                    begin
                        kind_next = KIND_WAIT;
                        none_next = 1'b1;
                    end
                    else if (pend_reg)
                    begin
                        kind_next  = KIND_EXPIRED;
                        xconn_next = pconn_reg;
                        xhnd_next  = phnd_reg;
                    end
                    else
                    begin
                        kind_next = KIND_NONE_DUE;
                    end
                end
            end
            S_DROP_EV:
            begin
                if (q_rd.dead || !live_stop)
                begin
                    head_next  = phys(head_reg, (AW+1)'(1));
                    count_next = count_reg - 1'b1;
                end
                if (!q_rd.dead)
                begin
                    res_valid_next = mode_reg == MODE_FIND || pend_reg || live_stop;
                    if (mode_reg == MODE_FIND)
                    begin
                        kind_next = KIND_WAIT;
                        if (alu_gt)
                        begin
                            wait_next = (alu_res[TIME_W-1:TMO_W] != '0) ? {TMO_W{1'b1}}
                                                                       : alu_res[TMO_W-1:0];
                        end
                    end
                    else if (pend_reg)
                    begin
                        kind_next  = KIND_EXPIRED;
                        xconn_next = pconn_reg;
                        xhnd_next  = phnd_reg;
                        last_next  = live_stop;
                    end
                    else
                    begin
                        kind_next = KIND_NONE_DUE;
                    end
                    if (!live_stop)
                    begin
                        pend_next  = 1'b1;
                        pconn_next = q_rd.conn;
                        phnd_next  = q_rd.hnd;
                        n_next     = n_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                q_we = 1'b0;
            end
        endcase

        if (ins_fire)
        begin
            q_we           = 1'b1;
            q_waddr        = pos_k;
            q_wdata        = new_entry;
            lt_we          = 1'b1;
            count_next     = count_reg + 1'b1;
            serial_next    = serial_reg + 1'b1;
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            head_reg      <= '0;
            count_reg     <= '0;
            k_reg         <= '0;
            n_reg         <= '0;
            serial_reg    <= '0;
            clr_reg       <= '0;
            pend_reg      <= 1'b0;
            mode_reg      <= MODE_ADD;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            k_reg         <= k_next;
            n_reg         <= n_next;
            serial_reg    <= serial_next;
            clr_reg       <= clr_next;
            pend_reg      <= pend_next;
            mode_reg      <= mode_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg    <= now_next;
        conn_reg   <= conn_next;
        tmo_reg    <= tmo_next;
        hnd_reg    <= hnd_next;
        dl_reg     <= dl_next;
        pconn_reg  <= pconn_next;
        phnd_reg   <= phnd_next;
        kind_reg   <= kind_next;
        status_reg <= status_next;
        xconn_reg  <= xconn_next;
        xhnd_reg   <= xhnd_next;
        wait_reg   <= wait_next;
        none_reg   <= none_next;
        last_reg   <= last_next;
    end

    assign busy               = state_reg != S_IDLE;
    assign result_valid       = res_valid_reg;
    assign kind               = kind_reg;
    assign status             = status_reg;
    assign expired_connection = xconn_reg;
    assign expired_handler    = xhnd_reg;
    assign wait_ms            = wait_reg;
    assign none_pending       = none_reg;
    assign last               = last_reg;

endmodule

### dv/tb_top.sv
// Self-checking bench for the timer queue with lazy deletion.
// Holds a driver, a monitor and a predictor of the deadline queue; needs tq_pkg and
// the timer_queue_lazy_delete RTL.
`timescale 1ns / 1ps

module tb_top;
    import tq_pkg::*;

    localparam int SLOTS = 64;
    localparam int LIMIT = 300000;
    localparam logic [39:0] TIME_TOP = 40'hFF_FFFF_FFFF;

    typedef struct {
        mode_t       md;
        logic [39:0] now;
        logic [7:0]  conn;
        logic [23:0] tmo;
        logic [3:0]  hnd;
        int          gap_pct;
        bit          drain;
    } word_t;

    typedef struct {
        kind_t       knd;
        status_t     st;
        logic [7:0]  conn;
        logic [3:0]  hnd;
        logic [23:0] wait_v;
        logic        none;
        logic        lst;
    } result_t;

    typedef struct {
        logic [39:0] dl;
        logic [7:0]  conn;
        logic [3:0]  hnd;
        logic [15:0] serial;
        bit          dead;
    } timer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [1:0] mode = '0;
    logic [39:0] now_ms = '0;
    logic [7:0] connection_id = '0;
    logic [23:0] timeout_ms = '0;
    logic [3:0] handler_id = '0;
    logic busy, result_valid, none_pending, last;
    logic [2:0] kind;
    logic [1:0] status;
    logic [7:0] expired_connection;
    logic [3:0] expired_handler;
    logic [23:0] wait_ms;

    word_t   pending_words[$];
    result_t expected_results[$];
    timer_t  deadline_queue[$];
    logic [16:0] latest_timer[256];
    logic [15:0] serial_ctr;
    word_t   in_flight;
    int      errors;
    int      cycles;
    logic [39:0] clock_ms;

    timer_queue_lazy_delete dut (
        .clk(clk), .rst_n(rst_n), .start(start), .mode(mode), .now_ms(now_ms),
        .connection_id(connection_id), .timeout_ms(timeout_ms),
        .handler_id(handler_id), .busy(busy), .result_valid(result_valid),
        .kind(kind), .status(status), .expired_connection(expired_connection),
        .expired_handler(expired_handler), .wait_ms(wait_ms),
        .none_pending(none_pending), .last(last)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    task automatic push_result(kind_t k, status_t s, logic [7:0] c, logic [3:0] h,
                               logic [23:0] w, logic n, logic l);
        result_t r;
        r.knd = k; r.st = s; r.conn = c; r.hnd = h; r.wait_v = w; r.none = n; r.lst = l;
        expected_results.push_back(r);
    endtask

    task automatic drop_dead_head();
        while (deadline_queue.size() > 0 && deadline_queue[0].dead)
            void'(deadline_queue.pop_front());
    endtask

    task automatic predict_word(word_t w);
        timer_t      t;
        logic [40:0] sum;
        logic [39:0] diff;
        int          pos;
        int          emitted;
        bit          hit;
        case (w.md)
            MODE_ADD:
            begin
                if (deadline_queue.size() >= SLOTS)
                    push_result(KIND_ADD_DONE, ST_FULL, '0, '0, '0, 1'b0, 1'b1);
                else
                begin
                    sum = {1'b0, w.now} + {17'd0, w.tmo};
                    t.dl = sum[40] ? TIME_TOP : sum[39:0];
                    t.conn = w.conn; t.hnd = w.hnd; t.serial = serial_ctr; t.dead = 1'b0;
                    pos = deadline_queue.size();
                    for (int i = 0; i < deadline_queue.size(); i++)
                        if (deadline_queue[i].dl > t.dl)
                        begin
                            pos = i;
                            break;
                        end
                    deadline_queue.insert(pos, t);
                    latest_timer[w.conn] = {1'b1, serial_ctr};
                    serial_ctr = serial_ctr + 16'd1;
                    push_result(KIND_ADD_DONE, ST_OK, '0, '0, '0, 1'b0, 1'b1);
                end
            end
            MODE_DELETE:
            begin
                hit = 1'b0;
                if (latest_timer[w.conn][16])
                    for (int i = 0; i < deadline_queue.size(); i++)
                        if (deadline_queue[i].conn == w.conn &&
                            deadline_queue[i].serial == latest_timer[w.conn][15:0])
                        begin
                            deadline_queue[i].dead = 1'b1;
                            hit = 1'b1;
                            break;
                        end
                push_result(KIND_DEL_DONE, hit ? ST_OK : ST_NO_TIMER, '0, '0, '0, 1'b0, 1'b1);
            end
            MODE_FIND:
            begin
                drop_dead_head();
                if (deadline_queue.size() == 0)
                    push_result(KIND_WAIT, ST_OK, '0, '0, '0, 1'b1, 1'b1);
                else
                begin
                    diff = (deadline_queue[0].dl > w.now) ? deadline_queue[0].dl - w.now : '0;
                    push_result(KIND_WAIT, ST_OK, '0, '0,
                                (diff > 40'hFF_FFFF) ? 24'hFF_FFFF : diff[23:0], 1'b0, 1'b1);
                end
            end
            default:
            begin
                emitted = 0;
                forever
                begin
                    drop_dead_head();
                    if (deadline_queue.size() == 0 || deadline_queue[0].dl > w.now ||
                        emitted >= MAX_OUT)
                        break;
                    t = deadline_queue.pop_front();
                    push_result(KIND_EXPIRED, ST_OK, t.conn, t.hnd, '0, 1'b0, 1'b0);
                    emitted++;
                end
                if (emitted == 0)
                    push_result(KIND_NONE_DUE, ST_OK, '0, '0, '0, 1'b0, 1'b1);
                else
                    expected_results[expected_results.size() - 1].lst = 1'b1;
            end
        endcase
    endtask

    task automatic report_mismatch(string field, logic [39:0] got, logic [39:0] want);
        if (got !== want)
        begin
            $display("mismatch at %0t: %s got %0h expected %0h", $realtime, field, got, want);
            errors++;
        end
    endtask

    // drive: hold a word until taken, then fetch the next one or idle
    always @(posedge clk or negedge rst_n)
    begin
        bit taken;
        bit issue;
        if (!rst_n)
        begin
            start <= 1'b0;
            mode <= '0;
            now_ms <= '0;
            connection_id <= '0;
            timeout_ms <= '0;
            handler_id <= '0;
        end
        else
        begin
            taken = start && !busy;
            if (taken)
                predict_word(in_flight);
            if (start && !taken)
                issue = 1'b0;
            else
                issue = pending_words.size() > 0 &&
                        (!pending_words[0].drain || (expected_results.size() == 0 && !busy)) &&
                        $urandom_range(99) >= pending_words[0].gap_pct;
            if (issue)
            begin
                in_flight = pending_words.pop_front();
                mode <= in_flight.md;
                now_ms <= in_flight.now;
                connection_id <= in_flight.conn;
                timeout_ms <= in_flight.tmo;
                handler_id <= in_flight.hnd;
                start <= 1'b1;
            end
            else if (!(start && !taken))
                start <= 1'b0;
        end
    end

    // check each strobed result against the oldest prediction
    always @(posedge clk)
    begin
        result_t r;
        if (rst_n && result_valid)
        begin
            if (expected_results.size() == 0)
            begin
                $display("unexpected result at %0t: kind %0d", $realtime, kind);
                errors++;
            end
            else
            begin
                r = expected_results.pop_front();
                report_mismatch("kind", kind, r.knd);
                report_mismatch("status", status, r.st);
                report_mismatch("expired_connection", expired_connection, r.conn);
                report_mismatch("expired_handler", expired_handler, r.hnd);
                report_mismatch("wait_ms", wait_ms, r.wait_v);
                report_mismatch("none_pending", none_pending, r.none);
                report_mismatch("last", last, r.lst);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic queue_word(mode_t m, logic [39:0] t, logic [7:0] c, logic [23:0] d,
                              logic [3:0] h, int gap, bit drain);
        word_t w;
        w.md = m; w.now = t; w.conn = c; w.tmo = d; w.hnd = h; w.gap_pct = gap; w.drain = drain;
        pending_words.push_back(w);
    endtask

    task automatic queue_random(int gap);
        int          pick;
        logic [23:0] d;
        logic [7:0]  c;
        clock_ms = clock_ms + $urandom_range(40);
        c = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(15));
        d = ($urandom_range(7) == 0) ? 24'($urandom) : 24'($urandom_range(150));
        pick = $urandom_range(99);
        if (pick < 40)
            queue_word(MODE_ADD, clock_ms, c, d, 4'($urandom), gap, 1'b0);
        else if (pick < 60)
            queue_word(MODE_DELETE, clock_ms, c, 24'($urandom), 4'($urandom), gap, 1'b0);
        else if (pick < 75)
            queue_word(MODE_FIND, clock_ms, c, 24'($urandom), 4'($urandom), gap, 1'b0);
        else
            queue_word(MODE_EXPIRE, clock_ms, c, 24'($urandom), 4'($urandom), gap, 1'b0);
    endtask

    initial
    begin
        int gaps[4];
        errors = 0;
        cycles = 0;
        serial_ctr = '0;
        foreach (latest_timer[i])
            latest_timer[i] = '0;
        gaps = '{0, 84, 0, 19};

        // directed: empty queue, saturation, extremes, lazy delete, zero handler
        queue_word(MODE_FIND, 40'd1000, 8'd0, 24'd0, 4'd0, 0, 1'b0);
        queue_word(MODE_EXPIRE, 40'd1000, 8'd0, 24'd0, 4'd0, 0, 1'b0);
        queue_word(MODE_DELETE, 40'd1000, 8'd255, 24'd0, 4'd0, 0, 1'b0);
        queue_word(MODE_ADD, 40'd1000, 8'd255, 24'hFF_FFFF, 4'hF, 0, 1'b0);
        queue_word(MODE_ADD, 40'd1000, 8'd1, 24'd10, 4'd0, 0, 1'b0);
        queue_word(MODE_ADD, 40'd1000, 8'd2, 24'd10, 4'd5, 0, 1'b0);
        queue_word(MODE_ADD, 40'd1000, 8'd3, 24'd0, 4'd7, 0, 1'b0);
        queue_word(MODE_FIND, 40'd1000, 8'd0, 24'd0, 4'd0, 0, 1'b0);
        queue_word(MODE_DELETE, 40'd1000, 8'd3, 24'd0, 4'd0, 0, 1'b0);
        queue_word(MODE_DELETE, 40'd1000, 8'd3, 24'd0, 4'd0, 0, 1'b0);
        queue_word(MODE_FIND, 40'd1005, 8'd0, 24'd0, 4'd0, 0, 1'b0);
        queue_word(MODE_EXPIRE, 40'd1005, 8'd0, 24'd0, 4'd0, 0, 1'b0);
        queue_word(MODE_EXPIRE, 40'd1010, 8'd0, 24'd0, 4'd0, 0, 1'b0);
        queue_word(MODE_DELETE, 40'd1010, 8'd1, 24'd0, 4'd0, 0, 1'b0);
        queue_word(MODE_FIND, 40'd1011, 8'd0, 24'd0, 4'd0, 0, 1'b0);
        queue_word(MODE_ADD, TIME_TOP - 40'd5, 8'd9, 24'hFF_FFFF, 4'd3, 0, 1'b0);
        queue_word(MODE_FIND, 40'd0, 8'd0, 24'd0, 4'd0, 0, 1'b0);
        queue_word(MODE_EXPIRE, 40'd500, 8'd0, 24'd0, 4'd0, 0, 1'b0);
        queue_word(MODE_EXPIRE, TIME_TOP, 8'd0, 24'd0, 4'd0, 0, 1'b0);
        queue_word(MODE_FIND, TIME_TOP, 8'd0, 24'd0, 4'd0, 0, 1'b0);

        foreach (gaps[p])
        begin
            clock_ms = {8'($urandom), 32'($urandom)} >> $urandom_range(24);
            for (int i = 0; i < 4; i++)
                queue_random(gaps[p]);
        end

        // fill to overflow after the queue has drained, then flush everything due
        clock_ms = 40'd50000;
        queue_word(MODE_EXPIRE, TIME_TOP, 8'd0, 24'd0, 4'd0, 0, 1'b1);
        for (int i = 0; i < SLOTS + 2; i++)
            queue_word(MODE_ADD, clock_ms, 8'($urandom), 24'($urandom_range(20)),
                       4'($urandom), 19, 1'b0);
        queue_word(MODE_DELETE, clock_ms, 8'($urandom), 24'd0, 4'd0, 19, 1'b0);
        queue_word(MODE_FIND, clock_ms, 8'd0, 24'd0, 4'd0, 19, 1'b0);
        queue_word(MODE_EXPIRE, clock_ms + 40'd30, 8'd0, 24'd0, 4'd0, 0, 1'b0);
        for (int i = 0; i < 4; i++)
            queue_random(19);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_words.size() > 0 || start || busy || expected_results.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

### sim.f
hw/rtl/tq_pkg.sv
hw/rtl/tq_ram.sv
hw/rtl/tq_alu.sv
hw/rtl/timer_queue_lazy_delete.sv
dv/tb_top.sv
